FILE: rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion shorthands for the checker file of the project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted
`define FRMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define FRMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/frma_pkg.sv
// ============================================================================
// frma_pkg
// Constants, register codes, widths and the final axis mapping function of
// the fisheye reverse map address generator.
// ============================================================================
`default_nettype none

package frma_pkg;

    // Fixed-point setup
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_FRAC  = FRAC_BITS / 2;
    localparam int FOCAL_FRAC = 16;
    localparam int MAX_DIM    = 4096;

    // Config register indexes
    localparam logic [2:0] CFG_FOCAL = 3'd0;
    localparam logic [2:0] CFG_DIST  = 3'd1;
    localparam logic [2:0] CFG_DW    = 3'd2;
    localparam logic [2:0] CFG_DH    = 3'd3;
    localparam logic [2:0] CFG_SW    = 3'd4;
    localparam logic [2:0] CFG_SH    = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    // Register reset values
    localparam logic [17:0] FOCAL_RST = 18'd65536;
    localparam logic [15:0] DIST_RST  = 16'd300;
    localparam logic [12:0] DW_RST    = 13'd500;
    localparam logic [12:0] DH_RST    = 13'd500;
    localparam logic [12:0] SW_RST    = 13'd1024;
    localparam logic [12:0] SH_RST    = 13'd1024;

    // Datapath widths
    localparam int P_W    = 14;                         // centred coordinate, signed
    localparam int SQ_W   = 25;                         // pu^2, pv^2
    localparam int H2_W   = 34;                         // pu^2 + pv^2 + d^2
    localparam int X1_W   = H2_W + 2 * ROOT_FRAC;       // first root radicand
    localparam int HQ_W   = X1_W / 2;                   // h in Q.ROOT_FRAC
    localparam int DH_W   = 16 + HQ_W;                  // d * h_q
    localparam int DQ_W   = 43;                         // h*(h+d) in Q.ROOT_FRAC
    localparam int X2_W   = DQ_W + 1 + ROOT_FRAC;       // second root radicand
    localparam int RQ_W   = X2_W / 2;                   // root_q
    localparam int MAG_W  = 13;                         // |pu|, |pv|
    localparam int M1_W   = 18 + MAG_W;                 // f * |p|
    localparam int M2_W   = M1_W + 12;                  // f * |p| * half
    localparam int NSH    = 1 + FRAC_BITS + ROOT_FRAC - FOCAL_FRAC;
    localparam int NUM_W  = M2_W + NSH;                 // dividend
    localparam int LIM_W  = 41;                         // saturated magnitude
    localparam int SUM_W  = LIM_W + 2;
    localparam int T_W    = SUM_W - FRAC_BITS;

    localparam logic [LIM_W-1:0] MAG_LIMIT = {1'b1, {(LIM_W-1){1'b0}}};

    // Side data through the first root pipeline
    typedef struct packed {
        logic [H2_W-1:0]       h2;
        logic signed [P_W-1:0] pu;
        logic signed [P_W-1:0] pv;
    } t_side_a;

    // Side data through the second root pipeline
    typedef struct packed {
        logic signed [P_W-1:0] pu;
        logic signed [P_W-1:0] pv;
    } t_side_b;

    // Per-axis result
    typedef struct packed {
        logic        ok;
        logic [11:0] coord;
    } t_axis;

    // Saturate, recentre, truncate toward zero and bound one axis
    function automatic t_axis map_axis(input logic [NUM_W-1:0] q, input logic zero,
                                       input logic neg, input logic [12:0] size);
        logic [LIM_W-1:0]        mag;
        logic [SUM_W-1:0]        half_sh;
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-1:0]        nsum;
        logic [T_W-1:0]          t;
        t_axis                   res;
        if (zero) begin
            mag = '0;
        end else if (q > NUM_W'(MAG_LIMIT)) begin
            mag = MAG_LIMIT;
        end else begin
            mag = q[LIM_W-1:0];
        end
        half_sh = SUM_W'({size[12:1], {FRAC_BITS{1'b0}}});
        if (neg) begin
            sum = $signed(half_sh - SUM_W'(mag));
        end else begin
            sum = $signed(half_sh + SUM_W'(mag));
        end
        res.ok = 1'b1;
        nsum   = '0;
        if (sum[SUM_W-1]) begin
            nsum = -$unsigned(sum);
            res.ok = (nsum[SUM_W-1:FRAC_BITS] == '0);
            t = '0;
        end else begin
            t = sum[SUM_W-1:FRAC_BITS];
        end
        if (t >= T_W'(size) || t >= T_W'(MAX_DIM)) begin
            res.ok = 1'b0;
        end
        res.coord = t[11:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/frma_isqrt.sv
// ============================================================================
// frma_isqrt
// Pipelined floor square root, one result bit per register stage, with a
// side bus that travels alongside.
// ============================================================================
`default_nettype none

module frma_isqrt #(
    parameter int IN_W   = 50,
    parameter int SIDE_W = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [IN_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic [IN_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic              r_vld  [OUT_W];
    logic [IN_W-1:0]   r_x    [OUT_W];
    logic [REM_W-1:0]  r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];

    for (genvar g = 0; g < OUT_W; g++) begin : g_stage
        logic              p_vld;
        logic [IN_W-1:0]   p_x;
        logic [REM_W-1:0]  p_rem;
        logic [OUT_W-1:0]  p_root;
        logic [SIDE_W-1:0] p_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [OUT_W-1:0]  n_root;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_x    = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_x    = r_x[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_side = r_side[g-1];
        end

        // Bring down the next bit pair and try root*4+1
        assign rem_sh = {p_rem[REM_W-3:0], p_x[IN_W-1 -: 2]};
        assign trial  = {p_root, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign n_rem  = ge ? (rem_sh - trial) : rem_sh;
        assign n_root = {p_root[OUT_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= {p_x[IN_W-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];

endmodule

`default_nettype wire

FILE: rtl/frma_div.sv
// ============================================================================
// frma_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// side bus that travels alongside.
// ============================================================================
`default_nettype none

module frma_div #(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 26,
    parameter int SIDE_W = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [DEN_W-1:0]    i_den,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic [NUM_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]        o_side
);

    logic              r_vld  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic              p_vld;
        logic [NUM_W-1:0]  p_num;
        logic [DEN_W-1:0]  p_den;
        logic [DEN_W-1:0]  p_rem;
        logic [NUM_W-1:0]  p_quo;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    rem_sh;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  n_rem;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_num  = i_num;
            assign p_den  = i_den;
            assign p_rem  = '0;
            assign p_quo  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_num  = r_num[g-1];
            assign p_den  = r_den[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_quo  = r_quo[g-1];
            assign p_side = r_side[g-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        assign rem_sh = {p_rem, p_num[NUM_W-1]};
        assign ge     = (rem_sh >= {1'b0, p_den});
        assign diff   = rem_sh - {1'b0, p_den};
        assign n_rem  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g]  <= {p_num[NUM_W-2:0], 1'b0};
                r_den[g]  <= p_den;
                r_rem[g]  <= n_rem;
                r_quo[g]  <= {p_quo[NUM_W-2:0], ge};
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/fisheye_reverse_map_address.sv
// ============================================================================
// fisheye_reverse_map_address
// Reverse-mapping address generator for equisolid fisheye undistortion.
// ============================================================================
// For each destination pixel (dest_u, dest_v) the block returns the fisheye
// source pixel to fetch and an in-bounds flag; out-of-bounds words carry zero
// coordinates. It takes one word per clock while the input is not stalled and
// passes each word through 112 register stages. The stages are the input and
// centring registers, squares and sum, a 25-stage root pipeline for h, a
// multiply and add, a 26-stage root pipeline for the radial scale, two
// multiply stages, a 52-stage divider per axis and the output register. A
// one-word skid register behind the output takes the word that arrives in the
// cycle the output stalls; the pipeline and the input stall only while that
// word waits. Configuration is written through a plain write port; the
// user must write it only while the pipeline is empty; it is not enforced.
`default_nettype none

module fisheye_reverse_map_address (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [frma_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [frma_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [11:0]                       i_dest_u,
    input  wire logic [11:0]                       i_dest_v,
    // Output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [11:0]                            o_src_u,
    output logic [11:0]                            o_src_v,
    output logic                                   o_in_bounds
);

    localparam int P_W   = frma_pkg::P_W;
    localparam int SQ_W  = frma_pkg::SQ_W;
    localparam int H2_W  = frma_pkg::H2_W;
    localparam int X1_W  = frma_pkg::X1_W;
    localparam int HQ_W  = frma_pkg::HQ_W;
    localparam int DH_W  = frma_pkg::DH_W;
    localparam int DQ_W  = frma_pkg::DQ_W;
    localparam int X2_W  = frma_pkg::X2_W;
    localparam int RQ_W  = frma_pkg::RQ_W;
    localparam int MAG_W = frma_pkg::MAG_W;
    localparam int M1_W  = frma_pkg::M1_W;
    localparam int M2_W  = frma_pkg::M2_W;
    localparam int NUM_W = frma_pkg::NUM_W;
    localparam int RF    = frma_pkg::ROOT_FRAC;
    localparam int SA_W  = $bits(frma_pkg::t_side_a);
    localparam int SB_W  = $bits(frma_pkg::t_side_b);

    // Config registers
    logic [17:0] r_focal;
    logic [15:0] r_dist;
    logic [12:0] r_dw;
    logic [12:0] r_dh;
    logic [12:0] r_sw;
    logic [12:0] r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= frma_pkg::FOCAL_RST;
            r_dist  <= frma_pkg::DIST_RST;
            r_dw    <= frma_pkg::DW_RST;
            r_dh    <= frma_pkg::DH_RST;
            r_sw    <= frma_pkg::SW_RST;
            r_sh    <= frma_pkg::SH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                frma_pkg::CFG_FOCAL: r_focal <= i_cfg_data;
                frma_pkg::CFG_DIST:  r_dist  <= i_cfg_data[15:0];
                frma_pkg::CFG_DW:    r_dw    <= i_cfg_data[12:0];
                frma_pkg::CFG_DH:    r_dh    <= i_cfg_data[12:0];
                frma_pkg::CFG_SW:    r_sw    <= i_cfg_data[12:0];
                frma_pkg::CFG_SH:    r_sh    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while the skid word waits
    logic r_out_vld;
    logic r_sk_vld;
    logic en;
    assign en         = !r_sk_vld;
    assign o_in_stall = r_sk_vld;

    // Stage A: input register
    logic        r_a_vld;
    logic [11:0] r_a_u;
    logic [11:0] r_a_v;
    // Stage B: centred coordinates
    logic                  r_b_vld;
    logic signed [P_W-1:0] r_b_pu;
    logic signed [P_W-1:0] r_b_pv;
    // Stage C: squares
    logic                  r_c_vld;
    logic [SQ_W-1:0]       r_c_pu2;
    logic [SQ_W-1:0]       r_c_pv2;
    logic [31:0]           r_c_d2;
    logic signed [P_W-1:0] r_c_pu;
    logic signed [P_W-1:0] r_c_pv;
    // Stage D: h^2
    logic                  r_d_vld;
    logic [H2_W-1:0]       r_d_h2;
    logic signed [P_W-1:0] r_d_pu;
    logic signed [P_W-1:0] r_d_pv;

    logic signed [2*P_W-1:0] pu_sq;
    logic signed [2*P_W-1:0] pv_sq;
    assign pu_sq = r_b_pu * r_b_pu;
    assign pv_sq = r_b_pv * r_b_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_u   <= i_dest_u;
            r_a_v   <= i_dest_v;
            r_b_pu  <= $signed({2'b00, r_a_u}) - $signed({2'b00, r_dw[12:1]});
            r_b_pv  <= $signed({2'b00, r_dh[12:1]}) - $signed({2'b00, r_a_v});
            r_c_pu2 <= pu_sq[SQ_W-1:0];
            r_c_pv2 <= pv_sq[SQ_W-1:0];
            r_c_d2  <= r_dist * r_dist;
            r_c_pu  <= r_b_pu;
            r_c_pv  <= r_b_pv;
            r_d_h2  <= H2_W'(r_c_pu2) + H2_W'(r_c_pv2) + H2_W'(r_c_d2);
            r_d_pu  <= r_c_pu;
            r_d_pv  <= r_c_pv;
        end
    end

    // h in Q.ROOT_FRAC
    frma_pkg::t_side_a side_a_in;
    frma_pkg::t_side_a side_a_out;
    logic [SA_W-1:0]   side_a_vec;
    logic              ra_vld;
    logic [HQ_W-1:0]   ra_hq;

    assign side_a_in = '{h2: r_d_h2, pu: r_d_pu, pv: r_d_pv};
    assign side_a_out = frma_pkg::t_side_a'(side_a_vec);

    frma_isqrt #(
        .IN_W   (X1_W),
        .SIDE_W (SA_W)
    ) u_root_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_rad   ({r_d_h2, {(2*RF){1'b0}}}),
        .i_side  (side_a_in),
        .o_valid (ra_vld),
        .o_root  (ra_hq),
        .o_side  (side_a_vec)
    );

    // Stage E: d*h_q; stage F: h*(h+d)
    logic                  r_e_vld;
    logic [DH_W-1:0]       r_e_dh;
    logic [H2_W-1:0]       r_e_h2;
    frma_pkg::t_side_b     r_e_side;
    logic                  r_f_vld;
    logic [DQ_W-1:0]       r_f_dq;
    frma_pkg::t_side_b     r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= ra_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_dh   <= r_dist * ra_hq;
            r_e_h2   <= side_a_out.h2;
            r_e_side <= '{pu: side_a_out.pu, pv: side_a_out.pv};
            r_f_dq   <= DQ_W'({r_e_h2, {RF{1'b0}}}) + DQ_W'(r_e_dh);
            r_f_side <= r_e_side;
        end
    end

    // sqrt(2*h*(h+d)) in Q.ROOT_FRAC
    logic              rb_vld;
    logic [RQ_W-1:0]   rb_rq;
    logic [SB_W-1:0]   side_b_vec;
    frma_pkg::t_side_b side_b_out;
    assign side_b_out = frma_pkg::t_side_b'(side_b_vec);

    frma_isqrt #(
        .IN_W   (X2_W),
        .SIDE_W (SB_W)
    ) u_root_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_rad   ({r_f_dq, {(RF+1){1'b0}}}),
        .i_side  (r_f_side),
        .o_valid (rb_vld),
        .o_root  (rb_rq),
        .o_side  (side_b_vec)
    );

    // Stage G: magnitudes times f (axes crossed: x uses pv, y uses pu)
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [P_W-1:0]   neg_pv;
    logic [P_W-1:0]   neg_pu;
    assign neg_pv = -$unsigned(side_b_out.pv);
    assign neg_pu = -$unsigned(side_b_out.pu);
    assign mag_x  = side_b_out.pv[P_W-1] ? neg_pv[MAG_W-1:0] : side_b_out.pv[MAG_W-1:0];
    assign mag_y  = side_b_out.pu[P_W-1] ? neg_pu[MAG_W-1:0] : side_b_out.pu[MAG_W-1:0];

    logic            r_g_vld;
    logic [M1_W-1:0] r_g_mx;
    logic [M1_W-1:0] r_g_my;
    logic            r_g_nx;
    logic            r_g_ny;
    logic [RQ_W-1:0] r_g_rq;
    // Stage H: times half extent
    logic            r_h_vld;
    logic [M2_W-1:0] r_h_mx;
    logic [M2_W-1:0] r_h_my;
    logic            r_h_nx;
    logic            r_h_ny;
    logic [RQ_W-1:0] r_h_rq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_g_vld <= rb_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_mx <= r_focal * mag_x;
            r_g_my <= r_focal * mag_y;
            r_g_nx <= side_b_out.pv[P_W-1];
            r_g_ny <= side_b_out.pu[P_W-1];
            r_g_rq <= rb_rq;
            r_h_mx <= r_g_mx * r_sw[12:1];
            r_h_my <= r_g_my * r_sh[12:1];
            r_h_nx <= r_g_nx;
            r_h_ny <= r_g_ny;
            r_h_rq <= r_g_rq;
        end
    end

    // Offsets: f*|p|*half scaled, over root_q
    logic             dx_vld;
    logic [NUM_W-1:0] dx_q;
    logic [1:0]       dx_side;
    logic             dy_vld;
    logic [NUM_W-1:0] dy_q;
    logic             dy_side;

    frma_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (RQ_W),
        .SIDE_W (2)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_vld),
        .i_num   ({r_h_mx, {frma_pkg::NSH{1'b0}}}),
        .i_den   (r_h_rq),
        .i_side  ({(r_h_rq == '0), r_h_nx}),
        .o_valid (dx_vld),
        .o_quo   (dx_q),
        .o_side  (dx_side)
    );

    frma_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (RQ_W),
        .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_vld),
        .i_num   ({r_h_my, {frma_pkg::NSH{1'b0}}}),
        .i_den   (r_h_rq),
        .i_side  (r_h_ny),
        .o_valid (dy_vld),
        .o_quo   (dy_q),
        .o_side  (dy_side)
    );

    // Output word: saturate, recentre, bound
    frma_pkg::t_axis ax_u;
    frma_pkg::t_axis ax_v;
    logic            all_ok;
    assign ax_u   = frma_pkg::map_axis(dx_q, dx_side[1], dx_side[0], r_sw);
    assign ax_v   = frma_pkg::map_axis(dy_q, dx_side[1], dy_side, r_sh);
    assign all_ok = ax_u.ok && ax_v.ok && dy_vld;

    logic [11:0] n_src_u;
    logic [11:0] n_src_v;
    logic        out_free;
    assign n_src_u  = all_ok ? ax_u.coord : 12'd0;
    assign n_src_v  = all_ok ? ax_v.coord : 12'd0;
    assign out_free = !r_out_vld || !i_out_stall;

    logic [11:0] r_src_u;
    logic [11:0] r_src_v;
    logic        r_ok;
    logic [11:0] r_sk_u;
    logic [11:0] r_sk_v;
    logic        r_sk_ok;

    // Output register and skid word valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            if (out_free) begin
                r_out_vld <= 1'b1;
                r_sk_vld  <= 1'b0;
            end
        end else if (out_free) begin
            r_out_vld <= dx_vld;
        end else if (dx_vld) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (out_free) begin
                r_src_u <= r_sk_u;
                r_src_v <= r_sk_v;
                r_ok    <= r_sk_ok;
            end
        end else if (out_free) begin
            r_src_u <= n_src_u;
            r_src_v <= n_src_v;
            r_ok    <= all_ok;
        end else begin
            r_sk_u  <= n_src_u;
            r_sk_v  <= n_src_v;
            r_sk_ok <= all_ok;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_src_u     = r_src_u;
    assign o_src_v     = r_src_v;
    assign o_in_bounds = r_ok;

endmodule

`default_nettype wire

FILE: rtl/frma_checker.sv
// ============================================================================
// frma_checker
// Port-level checks for the fisheye reverse map address generator.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module frma_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [11:0] o_src_u,
    input wire logic [11:0] o_src_v,
    input wire logic        o_in_bounds
);

    // A stalled output word holds
    `FRMA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_src_u) && $stable(o_src_v) && $stable(o_in_bounds), "stalled output word changed")

    // Out-of-bounds words carry zero coordinates
    `FRMA_ASSERT(a_oob_zero, o_out_valid && !o_in_bounds |-> o_src_u == 12'd0 && o_src_v == 12'd0, "out-of-bounds word with nonzero coordinate")

    // Input is held back only while an output word is pending
    `FRMA_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid, "input stalled with no output word")

    // Nothing comes out right after reset
    `FRMA_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind fisheye_reverse_map_address frma_checker u_frma_checker (.*);

`default_nettype wire
